// ===== rtl/plrb_pkg.sv =====
// shared types and constants for the packet log ring buffer
package plrb_pkg;

    // widths fixed by the request and result fields
    localparam int MODE_W   = 3;
    localparam int LEN_W    = 16;
    localparam int DATA_W   = 8;
    localparam int SKIP_W   = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 15;

    // request modes
    typedef enum logic [MODE_W-1:0] {
        MODE_START = 3'd0,
        MODE_BYTE  = 3'd1,
        MODE_POP   = 3'd2,
        MODE_SKIP  = 3'd3,
        MODE_FLUSH = 3'd4
    } t_mode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 3'd0,
        STATUS_EMPTY    = 3'd1,
        STATUS_NO_SPACE = 3'd2,
        STATUS_DISABLED = 3'd3,
        STATUS_DROPPED  = 3'd4
    } t_status;

endpackage

// ===== rtl/packet_log_ring_buffer.sv =====
// top level of the packet log ring buffer: pointer control around the byte store
//
// Usage: a request (mode, packet length, data byte, skip count) is taken at a
// rising edge with start high and busy low. busy stays low: every request is
// taken in the cycle it is offered, so one request per cycle is sustained.
// Each request gives exactly one result in the next cycle, shown for a single
// cycle with o_strobe high: read data, status, fill and free counts after the
// request. Pops read the byte store through its registered read port; the
// pointers live in registers and are updated in the request cycle.
// Packets are admitted whole: a start reserves its length against the free
// space; bytes are staged behind the write pointer and committed on the last.
// Configuration: i_cfg_we with i_cfg_wdata writes the enable bit; any write
// clears all pointers and the packet state. Write it only while idle.
// Reset (synchronous, active low) clears the pointers, packet state and the
// enable bit; store contents stay undefined until written.
// The receiver cannot stall: a result must be taken in its strobe cycle.
module packet_log_ring_buffer #(
    parameter int DEPTH = 32768
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [plrb_pkg::MODE_W-1:0]   i_mode,
    input  logic [plrb_pkg::LEN_W-1:0]    i_packet_length,
    input  logic [plrb_pkg::DATA_W-1:0]   i_data_byte,
    input  logic [plrb_pkg::SKIP_W-1:0]   i_skip_count,
    output logic                          o_strobe,
    output logic [plrb_pkg::DATA_W-1:0]   o_read_data,
    output logic [plrb_pkg::STATUS_W-1:0] o_status,
    output logic [plrb_pkg::COUNT_W-1:0]  o_fill_count,
    output logic [plrb_pkg::COUNT_W-1:0]  o_free_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (PW > plrb_pkg::LEN_W) ? PW : plrb_pkg::LEN_W;
    localparam logic [PW:0] DEPTH_V = (PW+1)'(DEPTH);

    // pointer registers
    logic [PW-1:0]              r_rp, n_rp;
    logic [PW-1:0]              r_wp, n_wp;
    logic [PW-1:0]              r_sp, n_sp;
    logic [plrb_pkg::LEN_W-1:0] r_rem, n_rem;
    logic                       r_drop, n_drop;
    logic                       r_enable;

    // result registers
    logic                       r_strobe;
    logic                       r_pop;
    plrb_pkg::t_status          r_status, n_status;

    logic                       accept;
    logic [PW-1:0]              fill;
    logic [PW-1:0]              free_sp;
    logic [PW-1:0]              skip_n;
    logic                       ram_we;
    logic                       ram_re;
    logic [plrb_pkg::DATA_W-1:0] ram_rdata;

    // pointer plus a step below the depth, wrapped once
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [PW-1:0] n);
        logic [PW:0] sum;
        sum = {1'b0, p} + {1'b0, n};
        if (sum >= DEPTH_V) begin
            sum = sum - DEPTH_V;
        end
        return sum[PW-1:0];
    endfunction

    assign accept = start && !busy;
    assign busy   = 1'b0;

    // committed fill and free space
    always_comb begin
        logic [PW:0] diff;
        if (r_wp >= r_rp) begin
            diff = {1'b0, r_wp} - {1'b0, r_rp};
        end else begin
            diff = {1'b0, r_wp} + DEPTH_V - {1'b0, r_rp};
        end
        fill    = diff[PW-1:0];
        free_sp = PW'(DEPTH_V - (PW+1)'(1) - {1'b0, fill});
    end

    // skip clamped to fill
    assign skip_n = (CW'(i_skip_count) < CW'(fill)) ? PW'(i_skip_count) : fill;

    // request decode and next pointer state
    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_sp     = r_sp;
        n_rem    = r_rem;
        n_drop   = r_drop;
        n_status = plrb_pkg::STATUS_OK;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        if (!r_enable) begin
            n_status = plrb_pkg::STATUS_DISABLED;
        end else begin
            case (plrb_pkg::t_mode'(i_mode))
                plrb_pkg::MODE_START: begin
                    n_drop = 1'b0;
                    n_rem  = i_packet_length;
                    n_sp   = r_wp;
                    if (i_packet_length != '0 && CW'(free_sp) < CW'(i_packet_length)) begin
                        n_drop   = 1'b1;
                        n_status = plrb_pkg::STATUS_NO_SPACE;
                    end
                end
                plrb_pkg::MODE_BYTE: begin
                    if (r_rem == '0) begin
                        n_status = plrb_pkg::STATUS_DROPPED;
                    end else if (r_drop) begin
                        n_rem    = r_rem - plrb_pkg::LEN_W'(1);
                        n_status = plrb_pkg::STATUS_DROPPED;
                        if (r_rem == plrb_pkg::LEN_W'(1)) begin
                            n_drop = 1'b0;
                        end
                    end else begin
                        ram_we = 1'b1;
                        n_sp   = advance(r_sp, PW'(1));
                        n_rem  = r_rem - plrb_pkg::LEN_W'(1);
                        if (r_rem == plrb_pkg::LEN_W'(1)) begin
                            n_wp = advance(r_sp, PW'(1));
                        end
                    end
                end
                plrb_pkg::MODE_POP: begin
                    if (fill == '0) begin
                        n_status = plrb_pkg::STATUS_EMPTY;
                    end else begin
                        ram_re = 1'b1;
                        n_rp   = advance(r_rp, PW'(1));
                    end
                end
                plrb_pkg::MODE_SKIP: begin
                    n_rp = advance(r_rp, skip_n);
                end
                plrb_pkg::MODE_FLUSH: begin
                    n_rp = r_wp;
                end
                default: begin
                    n_status = plrb_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // control registers; a configuration write clears the pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_rp     <= '0;
            r_wp     <= '0;
            r_sp     <= '0;
            r_rem    <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
            r_pop    <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
            r_rp     <= '0;
            r_wp     <= '0;
            r_sp     <= '0;
            r_rem    <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
            r_pop    <= 1'b0;
        end else begin
            r_strobe <= accept;
            r_pop    <= accept && ram_re;
            if (accept) begin
                r_rp   <= n_rp;
                r_wp   <= n_wp;
                r_sp   <= n_sp;
                r_rem  <= n_rem;
                r_drop <= n_drop;
            end
        end
    end

    // result status
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
    end

    // byte store
    plrb_ram #(
        .DEPTH (DEPTH),
        .AW    (PW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept && ram_we),
        .i_waddr (r_sp),
        .i_wdata (i_data_byte),
        .i_re    (accept && ram_re),
        .i_raddr (r_rp),
        .o_rdata (ram_rdata)
    );

    // result ports; counts follow the pointers left by the request
    assign o_strobe     = r_strobe;
    assign o_read_data  = r_pop ? ram_rdata : '0;
    assign o_status     = r_status;
    assign o_fill_count = plrb_pkg::COUNT_W'(fill);
    assign o_free_count = plrb_pkg::COUNT_W'(free_sp);

endmodule

// ===== rtl/plrb_ram.sv =====
// byte store of the ring buffer: one write port, one registered read port
module plrb_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [plrb_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [plrb_pkg::DATA_W-1:0] o_rdata
);

    logic [plrb_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [plrb_pkg::DATA_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered on the read enable
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/plrb_checker.sv =====
// port-level checks for the packet log ring buffer, bound to the top level
module plrb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [plrb_pkg::DATA_W-1:0]   o_read_data,
    input logic [plrb_pkg::STATUS_W-1:0] o_status,
    input logic [plrb_pkg::COUNT_W-1:0]  o_fill_count
);

    // every taken request answers in the next cycle
    a_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_strobe)
        else $error("request without result");

    // no result without a request
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_strobe)
        else $error("result without request");

    // read data only with an ok status
    a_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != plrb_pkg::STATUS_OK) |-> (o_read_data == '0))
        else $error("read data on failed request");

    // an empty pop reports zero fill
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == plrb_pkg::STATUS_EMPTY) |-> (o_fill_count == '0))
        else $error("empty status with nonzero fill");

endmodule

bind packet_log_ring_buffer plrb_checker u_plrb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_read_data  (o_read_data),
    .o_status     (o_status),
    .o_fill_count (o_fill_count)
);

// ===== sim/packet_log_ring_buffer_tb.sv =====
// self-checking testbench for the packet log ring buffer with its own ring model
module packet_log_ring_buffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RING_SLOTS  = 32768;
    localparam int          CYCLE_LIMIT = 400_000;
    localparam logic [plrb_pkg::COUNT_W-1:0] COUNT_MAX = '1;
    // mode codes with no function in the block
    localparam logic [plrb_pkg::MODE_W-1:0]  MODE_SPARE_FIRST = 3'd5;
    localparam logic [plrb_pkg::MODE_W-1:0]  MODE_SPARE_LAST  = 3'd7;

    typedef struct {
        logic [plrb_pkg::DATA_W-1:0]  read_data;
        plrb_pkg::t_status            status;
        logic [plrb_pkg::COUNT_W-1:0] fill_count;
        logic [plrb_pkg::COUNT_W-1:0] free_count;
    } t_ring_result;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic                          i_cfg_wdata;
    logic                          start;
    logic                          busy;
    logic [plrb_pkg::MODE_W-1:0]   i_mode;
    logic [plrb_pkg::LEN_W-1:0]    i_packet_length;
    logic [plrb_pkg::DATA_W-1:0]   i_data_byte;
    logic [plrb_pkg::SKIP_W-1:0]   i_skip_count;
    logic                          o_strobe;
    logic [plrb_pkg::DATA_W-1:0]   o_read_data;
    logic [plrb_pkg::STATUS_W-1:0] o_status;
    logic [plrb_pkg::COUNT_W-1:0]  o_fill_count;
    logic [plrb_pkg::COUNT_W-1:0]  o_free_count;

    // ring model state
    logic [plrb_pkg::DATA_W-1:0]  model_store [RING_SLOTS];
    logic [plrb_pkg::COUNT_W-1:0] model_rd_ptr    = '0;
    logic [plrb_pkg::COUNT_W-1:0] model_wr_ptr    = '0;
    logic [plrb_pkg::COUNT_W-1:0] model_stage_ptr = '0;
    logic [plrb_pkg::LEN_W-1:0]   model_remaining = '0;
    bit                           model_dropping  = 1'b0;
    bit                           model_enabled   = 1'b0;

    t_ring_result awaited_results [$];

    int  failures        = 0;
    int  results_checked = 0;
    int  requests_sent   = 0;
    int  packets_committed = 0;
    int  packets_refused = 0;
    int  cycle_count     = 0;
    bit  steady          = 1'b0;

    packet_log_ring_buffer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_packet_length (i_packet_length),
        .i_data_byte     (i_data_byte),
        .i_skip_count    (i_skip_count),
        .o_strobe        (o_strobe),
        .o_read_data     (o_read_data),
        .o_status        (o_status),
        .o_fill_count    (o_fill_count),
        .o_free_count    (o_free_count)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("packet_log_ring_buffer_tb NOT OK");
            $finish;
        end
    end

    function automatic logic [plrb_pkg::COUNT_W-1:0] model_fill();
        return model_wr_ptr - model_rd_ptr;
    endfunction

    function automatic int model_free();
        return RING_SLOTS - 1 - int'(model_fill());
    endfunction

    // ring model: applies one accepted request and queues the result it must give
    task automatic ring_model_request(input logic [plrb_pkg::MODE_W-1:0] mode,
            input logic [plrb_pkg::LEN_W-1:0] len, input logic [plrb_pkg::DATA_W-1:0] data,
            input logic [plrb_pkg::SKIP_W-1:0] skip);
        t_ring_result                 res;
        logic [plrb_pkg::COUNT_W-1:0] fill;
        res.read_data = '0;
        res.status    = plrb_pkg::STATUS_OK;
        fill          = model_fill();
        if (!model_enabled) begin
            res.status = plrb_pkg::STATUS_DISABLED;
        end else begin
            case (mode)
                plrb_pkg::MODE_START: begin
                    // a new start abandons whatever packet was open
                    model_dropping  = 1'b0;
                    model_remaining = '0;
                    model_stage_ptr = model_wr_ptr;
                    if (len != 0) begin
                        model_remaining = len;
                        if (model_free() < int'(len)) begin
                            model_dropping = 1'b1;
                            res.status     = plrb_pkg::STATUS_NO_SPACE;
                            packets_refused++;
                        end
                    end
                end
                plrb_pkg::MODE_BYTE: begin
                    if (model_remaining == 0) begin
                        res.status = plrb_pkg::STATUS_DROPPED;
                    end else if (model_dropping) begin
                        model_remaining--;
                        if (model_remaining == 0) model_dropping = 1'b0;
                        res.status = plrb_pkg::STATUS_DROPPED;
                    end else begin
                        // stage the byte, commit on the last one
                        model_store[model_stage_ptr] = data;
                        model_stage_ptr++;
                        model_remaining--;
                        if (model_remaining == 0) begin
                            model_wr_ptr = model_stage_ptr;
                            packets_committed++;
                        end
                    end
                end
                plrb_pkg::MODE_POP: begin
                    if (fill == 0) begin
                        res.status = plrb_pkg::STATUS_EMPTY;
                    end else begin
                        res.read_data = model_store[model_rd_ptr];
                        model_rd_ptr++;
                    end
                end
                plrb_pkg::MODE_SKIP: begin
                    model_rd_ptr = model_rd_ptr
                                 + ((skip < fill) ? skip[plrb_pkg::COUNT_W-1:0] : fill);
                end
                plrb_pkg::MODE_FLUSH: begin
                    model_rd_ptr = model_wr_ptr;
                end
                default: begin
                end
            endcase
        end
        res.fill_count = model_fill();
        res.free_count = COUNT_MAX - res.fill_count;
        awaited_results.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
            input logic [15:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // result checker: every strobe is matched against the oldest awaited result
    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                failures++;
                $display("%0t: result with nothing awaited, expected none, got status %0d",
                         $time, o_status);
            end else begin
                want = awaited_results.pop_front();
                check_field("read_data", 16'(want.read_data), 16'(o_read_data));
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("fill_count", 16'(want.fill_count), 16'(o_fill_count));
                check_field("free_count", 16'(want.free_count), 16'(o_free_count));
                results_checked++;
            end
        end
    end

    // one request: held until taken, then passed to the model
    task automatic send_request(input logic [plrb_pkg::MODE_W-1:0] mode,
            input logic [plrb_pkg::LEN_W-1:0] len, input logic [plrb_pkg::DATA_W-1:0] data,
            input logic [plrb_pkg::SKIP_W-1:0] skip);
        start           <= 1'b1;
        i_mode          <= mode;
        i_packet_length <= len;
        i_data_byte     <= data;
        i_skip_count    <= skip;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ring_model_request(mode, len, data, skip);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // request whose unused fields carry noise
    task automatic send_noisy(input logic [plrb_pkg::MODE_W-1:0] mode);
        send_request(mode, plrb_pkg::LEN_W'($urandom), plrb_pkg::DATA_W'($urandom),
                     plrb_pkg::SKIP_W'($urandom));
    endtask

    task automatic send_byte(input logic [plrb_pkg::DATA_W-1:0] data);
        send_request(plrb_pkg::MODE_BYTE, plrb_pkg::LEN_W'($urandom), data,
                     plrb_pkg::SKIP_W'($urandom));
    endtask

    task automatic send_start(input logic [plrb_pkg::LEN_W-1:0] len);
        send_request(plrb_pkg::MODE_START, len, plrb_pkg::DATA_W'($urandom),
                     plrb_pkg::SKIP_W'($urandom));
    endtask

    task automatic send_pop();
        send_request(plrb_pkg::MODE_POP, '0, '0, '0);
    endtask

    // random gap on the request side, mostly short
    task automatic sender_pause();
        int roll;
        int cycles;
        if (steady) return;
        roll = $urandom_range(0, 99);
        if (roll < 60) cycles = 0;
        else if (roll < 92) cycles = $urandom_range(1, 3);
        else cycles = $urandom_range(4, 40);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // drain all results before touching the register
    task automatic wait_until_drained();
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_enable_reg(input bit value);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        model_enabled   = value;
        model_rd_ptr    = '0;
        model_wr_ptr    = '0;
        model_stage_ptr = '0;
        model_remaining = '0;
        model_dropping  = 1'b0;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // reset value of the register: everything answers disabled
    task automatic test_disabled_after_reset();
        send_pop();
        send_start(16'd4);
        send_byte(8'h11);
    endtask

    // each mode and corner on a nearly empty ring
    task automatic test_basic_modes();
        write_enable_reg(1'b1);
        send_request(plrb_pkg::MODE_POP, '1, '1, '1);
        send_byte(8'hFF);                          // stray byte
        send_request(plrb_pkg::MODE_SKIP, '0, '0, '1);
        send_request(plrb_pkg::MODE_FLUSH, '0, '0, '0);
        send_start(16'd0);                         // zero-length start
        send_byte(8'h3C);                          // stray after zero-length start
        send_start(16'd3);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hA5);
        send_pop();
        send_request(plrb_pkg::MODE_SKIP, '0, '0, 16'hFFFF); // clamped to fill
        send_start(16'hFFFF);                      // refused packet
        send_byte(8'h01);
        send_byte(8'h02);
        send_start(16'd2);                         // abandons the refused one
        send_byte(8'h5A);
        send_start(16'd1);                         // abandons the staged byte
        send_pop();
        send_request(plrb_pkg::MODE_FLUSH, '0, '0, '0); // staging left alone
        send_byte(8'hC3);
        for (logic [plrb_pkg::MODE_W:0] m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            send_noisy(m[plrb_pkg::MODE_W-1:0]);
        send_pop();
        send_pop();
    endtask

    // admission exactly at the free space and one byte over it
    task automatic test_admission_boundary();
        int room;
        write_enable_reg(1'b1);
        send_start(16'd32768);                     // one over an empty ring
        send_start(16'd32767);                     // exact fit on an empty ring
        repeat (6) send_byte(plrb_pkg::DATA_W'($urandom));
        send_pop();                                // staged bytes stay hidden
        send_start(16'd5);                         // abandons the large packet
        repeat (5) send_byte(plrb_pkg::DATA_W'($urandom));
        room = model_free();
        send_start(plrb_pkg::LEN_W'(room + 1));
        repeat (2) send_byte(plrb_pkg::DATA_W'($urandom));
        send_start(plrb_pkg::LEN_W'(room));
        repeat (3) send_byte(plrb_pkg::DATA_W'($urandom));
        send_start(16'd3);
        repeat (3) send_byte(plrb_pkg::DATA_W'($urandom));
        send_request(plrb_pkg::MODE_SKIP, '0, '0, 16'd2);
        repeat (10) send_pop();
    endtask

    // mostly whole packets with random content, mixed with reads and noise
    task automatic random_traffic(input int quota, input bit with_flush);
        int taken;
        int roll;
        int len;
        int nbytes;
        taken = 0;
        while (taken < quota) begin
            steady = ($urandom_range(0, 4) == 0);
            roll   = $urandom_range(0, 99);
            sender_pause();
            if (roll < 55) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) len = 0;
                else if (roll < 88) len = $urandom_range(1, 12);
                else len = $urandom_range(13, 48);
                // some packets are cut short and abandoned by the next start
                nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
                send_start(plrb_pkg::LEN_W'(len));
                taken++;
                for (int i = 0; i < nbytes; i++) begin
                    sender_pause();
                    if ($urandom_range(0, 9) == 0) begin
                        send_noisy(($urandom_range(0, 1) != 0) ? plrb_pkg::MODE_POP
                                                               : plrb_pkg::MODE_SKIP);
                        taken++;
                    end
                    send_byte(plrb_pkg::DATA_W'($urandom));
                    taken++;
                end
            end else if (roll < 75) begin
                send_noisy(plrb_pkg::MODE_POP);
                taken++;
            end else if (roll < 83) begin
                send_request(plrb_pkg::MODE_SKIP, plrb_pkg::LEN_W'($urandom),
                             plrb_pkg::DATA_W'($urandom),
                             ($urandom_range(0, 2) != 0)
                                 ? plrb_pkg::SKIP_W'($urandom_range(0, 8))
                                 : plrb_pkg::SKIP_W'($urandom));
                taken++;
            end else if (roll < 86) begin
                if (with_flush) begin
                    send_noisy(plrb_pkg::MODE_FLUSH);
                    taken++;
                end
            end else if (roll < 90) begin
                send_byte(plrb_pkg::DATA_W'($urandom));
                taken++;
            end else if (roll < 93) begin
                send_noisy(plrb_pkg::MODE_W'($urandom_range(MODE_SPARE_FIRST,
                                                             MODE_SPARE_LAST)));
            end else begin
                // start with a random length, often over the free space, then a few of its bytes
                send_start(plrb_pkg::LEN_W'($urandom));
                taken++;
                repeat ($urandom_range(0, 4)) begin
                    sender_pause();
                    send_byte(plrb_pkg::DATA_W'($urandom));
                    taken++;
                end
            end
        end
        steady = 1'b0;
    endtask

    // random traffic with no flushes, continuing from the boundary test
    task automatic test_random_no_flush();
        random_traffic(680, 1'b0);
    endtask

    // closing the buffer: every mode answers disabled
    task automatic test_disabled_phase();
        write_enable_reg(1'b0);
        repeat (24) begin
            sender_pause();
            send_noisy(plrb_pkg::MODE_W'($urandom_range(0, MODE_SPARE_LAST)));
        end
    endtask

    // random traffic from an empty ring
    task automatic test_random_from_empty();
        write_enable_reg(1'b1);
        random_traffic(1150, 1'b1);
    endtask

    // main sequence
    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        start           <= 1'b0;
        i_mode          <= plrb_pkg::MODE_START;
        i_packet_length <= '0;
        i_data_byte     <= '0;
        i_skip_count    <= '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_disabled_after_reset();
        test_basic_modes();
        test_admission_boundary();
        test_random_no_flush();
        test_disabled_phase();
        test_random_from_empty();

        // drain and let the last result settle
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            failures++;
            $display("%0t: %0d results still awaited, expected 0", $time,
                     awaited_results.size());
        end

        $display("sent %0d requests, checked %0d results", requests_sent, results_checked);
        $display("%0d packets committed, %0d refused, admission at the exact free space included",
                 packets_committed, packets_refused);
        if (failures == 0) begin
            $display("packet_log_ring_buffer_tb OK");
        end else begin
            $display("packet_log_ring_buffer_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== packet_log_ring_buffer.f =====
rtl/plrb_pkg.sv
rtl/plrb_ram.sv
rtl/packet_log_ring_buffer.sv
rtl/plrb_checker.sv
sim/packet_log_ring_buffer_tb.sv
